>>> design/heap_sorter_assert.svh
// ----------------------------------------------------------------------------
// heap_sorter assertion macros
// Shorthand for the concurrent checks of the heap sorter. Every check samples
// on the rising clock edge and is switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORTER_ASSERT_SVH
`define HEAP_SORTER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define HS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("heap_sorter: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define HS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap_sorter: same-cycle check failed");

// A consequence that must hold in the cycle after its trigger.
`define HS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap_sorter: next-cycle check failed");

`endif

>>> design/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and constants of the heap sorter.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_LD,
        ST_B_X,
        ST_B_CMP,
        ST_B_PUT,
        ST_S_RD,
        ST_S_SW,
        ST_S_CH,
        ST_S_PK,
        ST_S_PUT,
        ST_E_RD,
        ST_E_LD
    } t_state;

endpackage

>>> design/hs_cmp.sv
// ----------------------------------------------------------------------------
// hs_cmp
// Shared signed greater-than compare unit of the heap sorter.
// ----------------------------------------------------------------------------
module hs_cmp
    import hs_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

>>> design/hs_mem.sv
// ----------------------------------------------------------------------------
// hs_mem
// Heap storage: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hs_mem
    import hs_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> design/heap_sorter.sv
// ----------------------------------------------------------------------------
// heap_sorter
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_value, i_last
//  out     | from block| o_out_valid / i_out_stall | o_sorted_value, o_final_res,
//          |           |                           | o_overflow
//
//  A non-last beat is taken without stalling the input. The last beat starts the
//  sort on the single compare unit and registered memory read: a heap build that
//  sifts each element up, then extractions that each swap the root to the heap end
//  and sift down. Each result is a memory read, then an output load that waits
//  while the output stalls. Reset clears control state, not the heap; the input
//  stays stalled until the final result of the set is in the output register.
//
// ----------------------------------------------------------------------------
`include "heap_sorter_assert.svh"

module heap_sorter
    import hs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_res,
    output logic                     o_overflow
);

    // Address width covers entries 0 .. CAPACITY-1; the count also holds CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer and bookkeeping registers.
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt,   n_cnt;     // stored elements of the current set
    logic              r_ovf,   n_ovf;     // a beat was dropped in this set
    logic [CW-1:0]     r_k,     n_k;       // element being sifted up
    logic [AW-1:0]     r_c,     n_c;       // hole position during sift-up
    logic [AW-1:0]     r_e,     n_e;       // last index of the shrinking heap
    logic [AW-1:0]     r_r,     n_r;       // hole position during sift-down
    logic [AW-1:0]     r_pick,  n_pick;    // larger child chosen for sift-down
    logic [AW-1:0]     r_i,     n_i;       // emission index
    logic [DATA_W-1:0] r_x,     n_x;       // value travelling through the heap
    logic [DATA_W-1:0] r_pv,    n_pv;      // value of the chosen child

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_final;
    logic              r_out_ovf;

    // Memory and compare unit connections.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr_a;
    logic [AW-1:0]     mem_raddr_b;
    logic [DATA_W-1:0] mem_rdata_a;
    logic [DATA_W-1:0] mem_rdata_b;
    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;
    logic              cmp_gt;

    // Index arithmetic shared by the states below.
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     k_m1;
    logic [CW-1:0]     k_inc;
    logic [AW-1:0]     par_k;
    logic [AW-1:0]     par_c;
    logic [AW-1:0]     par_p;
    logic [AW:0]       e_ext;
    logic [AW:0]       l_r;
    logic [AW:0]       l_pk;
    logic [AW:0]       rr_r;
    logic [AW:0]       rr_pk;
    logic              out_free;
    logic              out_load;
    logic              last_i;

    // Conditions watched by the checks at the end.
    logic              sort_head;
    logic              set_done;
    logic              set_empty;

    hs_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    hs_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    assign cnt_inc = r_cnt + CW'(1);
    assign cnt_m1  = r_cnt - CW'(1);
    assign k_m1    = r_k - CW'(1);
    assign k_inc   = r_k + CW'(1);
    assign par_k   = AW'(k_m1 >> 1);
    assign par_c   = (r_c - AW'(1)) >> 1;
    assign par_p   = (par_c - AW'(1)) >> 1;
    assign e_ext   = {1'b0, r_e};
    // Left child of a node is 2*node+1, the right child follows it.
    assign l_r     = {r_r, 1'b1};
    assign l_pk    = {r_pick, 1'b1};
    assign rr_r    = l_r + (AW+1)'(1);
    assign rr_pk   = l_pk + (AW+1)'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_i   = (r_i == cnt_m1[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_c    <= n_c;
        r_e    <= n_e;
        r_r    <= n_r;
        r_pick <= n_pick;
        r_i    <= n_i;
        r_x    <= n_x;
        r_pv   <= n_pv;
    end

    // The output register is loaded only when it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= mem_rdata_a;
            r_out_final <= last_i;
            r_out_ovf   <= r_ovf;
        end
    end

    // Sequencer. The heap is sifted with a travelling hole: the moving value
    // stays in r_x and only displaced neighbors are written back, which gives
    // the same contents as a chain of pairwise swaps.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_c         = r_c;
        n_e         = r_e;
        n_r         = r_r;
        n_pick      = r_pick;
        n_i         = r_i;
        n_x         = r_x;
        n_pv        = r_pv;
        mem_we      = 1'b0;
        mem_waddr   = r_r;
        mem_wdata   = r_x;
        mem_raddr_a = r_i;
        mem_raddr_b = r_e;
        cmp_a       = r_x;
        cmp_b       = mem_rdata_a;
        out_load    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (r_cnt < CW'(CAPACITY)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cnt[AW-1:0];
                        mem_wdata = i_value;
                        n_cnt     = cnt_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        if (n_cnt > CW'(1)) begin
                            n_k     = CW'(1);
                            n_state = ST_B_LD;
                        end else begin
                            n_i     = '0;
                            n_state = ST_E_RD;
                        end
                    end
                end
            end

            // Heap build: fetch element k.
            ST_B_LD: begin
                mem_raddr_a = r_k[AW-1:0];
                n_state     = ST_B_X;
            end

            // Latch element k and fetch its parent.
            ST_B_X: begin
                n_x         = mem_rdata_a;
                n_c         = r_k[AW-1:0];
                mem_raddr_a = par_k;
                n_state     = ST_B_CMP;
            end

            // Move the parent down while the travelling value is larger.
            ST_B_CMP: begin
                cmp_a = r_x;
                cmp_b = mem_rdata_a;
                if (cmp_gt) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_c;
                    mem_wdata   = mem_rdata_a;
                    n_c         = par_c;
                    mem_raddr_a = par_p;
                    if (par_c == '0) begin
                        n_state = ST_B_PUT;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_c;
                    mem_wdata = r_x;
                    n_k       = k_inc;
                    if (k_inc == r_cnt) begin
                        n_e     = cnt_m1[AW-1:0];
                        n_state = ST_S_RD;
                    end else begin
                        n_state = ST_B_LD;
                    end
                end
            end

            // The value reached the root.
            ST_B_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_c;
                mem_wdata = r_x;
                n_k       = k_inc;
                if (k_inc == r_cnt) begin
                    n_e     = cnt_m1[AW-1:0];
                    n_state = ST_S_RD;
                end else begin
                    n_state = ST_B_LD;
                end
            end

            // Extraction: fetch the root and the end of the heap.
            ST_S_RD: begin
                mem_raddr_a = '0;
                mem_raddr_b = r_e;
                n_state     = ST_S_SW;
            end

            // Root goes to the end; the old end value starts at the root.
            ST_S_SW: begin
                mem_we      = 1'b1;
                mem_waddr   = r_e;
                mem_wdata   = mem_rdata_a;
                n_x         = mem_rdata_b;
                n_r         = '0;
                n_e         = r_e - AW'(1);
                mem_raddr_a = AW'(1);
                mem_raddr_b = AW'(2);
                if (r_e == AW'(1)) begin
                    n_state = ST_S_PUT;
                end else begin
                    n_state = ST_S_CH;
                end
            end

            // Choose the larger child; on a tie the right one is taken.
            ST_S_CH: begin
                cmp_a = mem_rdata_a;
                cmp_b = mem_rdata_b;
                if ((l_r < e_ext) && !cmp_gt) begin
                    n_pick = rr_r[AW-1:0];
                    n_pv   = mem_rdata_b;
                end else begin
                    n_pick = l_r[AW-1:0];
                    n_pv   = mem_rdata_a;
                end
                n_state = ST_S_PK;
            end

            // Move the child up while it is larger than the travelling value.
            ST_S_PK: begin
                cmp_a = r_pv;
                cmp_b = r_x;
                mem_we = 1'b1;
                mem_waddr = r_r;
                if (cmp_gt) begin
                    mem_wdata   = r_pv;
                    n_r         = r_pick;
                    mem_raddr_a = l_pk[AW-1:0];
                    mem_raddr_b = rr_pk[AW-1:0];
                    if (l_pk <= e_ext) begin
                        n_state = ST_S_CH;
                    end else begin
                        n_state = ST_S_PUT;
                    end
                end else begin
                    mem_wdata = r_x;
                    n_state   = ST_S_RD;
                end
            end

            ST_S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_r;
                mem_wdata = r_x;
                if (r_e == '0) begin
                    n_i     = '0;
                    n_state = ST_E_RD;
                end else begin
                    n_state = ST_S_RD;
                end
            end

            // Emission: read entry i, then hand it to the output register.
            ST_E_RD: begin
                mem_raddr_a = r_i;
                n_state     = ST_E_LD;
            end

            ST_E_LD: begin
                mem_raddr_a = r_i;
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_i) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = ST_E_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;
    assign o_overflow     = r_out_ovf;

    assign sort_head = (r_state == ST_S_RD) || (r_state == ST_S_SW);
    assign set_done  = out_load && last_i;
    assign set_empty = (r_cnt == '0) && !r_ovf && (r_state == ST_IDLE);

    // The count never passes the heap capacity.
    `HS_ASSERT_ALWAYS(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(CAPACITY))
    // A dropped beat can only have happened with a full heap.
    `HS_ASSERT_IMPL(a_ovf_full, i_clk, i_rst_n, r_ovf, r_cnt == CW'(CAPACITY))
    // The shrinking heap end always lies inside the stored set while sorting.
    `HS_ASSERT_IMPL(a_end_in_set, i_clk, i_rst_n, sort_head, CW'(r_e) < r_cnt)
    // Loading the final result of a set clears the set for the next one.
    `HS_ASSERT_NEXT(a_set_cleared, i_clk, i_rst_n, set_done, set_empty)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: heap_sorter testbench
// Streams sets of signed values into the sorter and checks every returned beat
// against a software sort of the same set. This covers overflow of the store,
// the dropped last beat, and random idling and stalling on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import hs_pkg::*;
();

    localparam int CAPACITY    = 64;
    localparam int DRAIN_WAIT  = 200;   // cycles of quiet after the last result
    localparam int LIMIT_NS    = 5_000_000;

    // One beat offered on the input channel. hold_for_drain makes the sender
    // pause until every expected result of earlier sets has come back.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     hold_for_drain;
    } t_in_beat;

    // One beat expected on the output channel.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     final_res;
        logic                     overflow;
    } t_sorted_beat;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_last      = 1'b0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_final_res;
    logic                     o_overflow;

    t_in_beat     pending_beats[$];
    t_sorted_beat sorted_q[$];

    // Copy of the sorter's state: values collected for the current set,
    // how many of them are held, and whether any beat was dropped.
    logic signed [DATA_W-1:0] held_vals [CAPACITY];
    int                       held_count   = 0;
    logic                     held_dropped = 1'b0;

    int mismatches  = 0;
    int total_beats = 1;
    int loaded      = 0;
    int phase       = 0;

    // Idling per phase: first the sender idles lightly while the receiver
    // stalls heavily, then the other way round, then neither side idles.
    int tx_idle_pct  [3] = '{14, 54, 0};
    int rx_stall_pct [3] = '{54, 14, 0};

    heap_sorter #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sorted_value(o_sorted_value),
        .o_final_res   (o_final_res),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Takes in one accepted beat. A beat is stored while there is room and
    // otherwise dropped with the overflow mark set. On the last beat the held
    // set is sorted ascending and one expected result per value is queued,
    // after which the set starts empty again.
    task automatic absorb_beat(input logic signed [DATA_W-1:0] v, input logic lst);
        logic signed [DATA_W-1:0] key;
        t_sorted_beat             res;
        int                       i;
        int                       j;
        if (held_count < CAPACITY) begin
            held_vals[held_count] = v;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (lst) begin
            // Insertion sort: the order of equal values cannot be seen at the
            // output, so any correct sort gives the same result stream.
            for (i = 1; i < held_count; i++) begin
                key = held_vals[i];
                j   = i - 1;
                while (j >= 0 && held_vals[j] > key) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            for (i = 0; i < held_count; i++) begin
                res.value     = held_vals[i];
                res.final_res = (i == held_count - 1);
                res.overflow  = held_dropped;
                sorted_q.push_back(res);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input t_sorted_beat want);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t ns %s: expected value %0d final %b overflow %b",
                   $time, what, want.value, want.final_res, want.overflow);
            $display(", got value %0d final %b overflow %b",
                     o_sorted_value, o_final_res, o_overflow);
        end
    endtask

    // Values lean toward the extremes and toward a narrow band around zero,
    // so that duplicates and sign boundaries turn up often.
    function automatic logic signed [DATA_W-1:0] draw_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            return ($urandom_range(1) != 0) ? {1'b0, {(DATA_W-1){1'b1}}}
                                            : {1'b1, {(DATA_W-1){1'b0}}};
        end else if (sel < 35) begin
            return $signed($urandom_range(16)) - 8;
        end
        return $urandom;
    endfunction

    task automatic queue_beat(input logic signed [DATA_W-1:0] v, input logic lst,
                              input logic hold);
        t_in_beat b;
        b.value          = v;
        b.last           = lst;
        b.hold_for_drain = hold;
        pending_beats.push_back(b);
    endtask

    // Queues a set of random values; only its final beat carries last.
    task automatic queue_random_set(input int count, input logic hold);
        int k;
        for (k = 0; k < count; k++) begin
            queue_beat(draw_value(), k == count - 1, hold && k == 0);
        end
    endtask

    // Input driver. An offered beat stays unchanged while the sorter stalls
    // it. Otherwise the next pending beat is offered, unless the sender idles
    // this cycle or the beat must wait for all outstanding results.
    always @(posedge i_clk) begin : drive_in
        t_in_beat nxt;
        logic     holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_beat(i_value, i_last);
            end
            holding = i_in_valid && o_in_stall;
            if (!holding) begin
                if (pending_beats.size() != 0
                        && !(pending_beats[0].hold_for_drain && sorted_q.size() != 0)
                        && $urandom_range(99) >= tx_idle_pct[phase]) begin
                    nxt = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_value    <= nxt.value;
                    i_last     <= nxt.last;
                    loaded++;
                    phase = (loaded * 3) / total_beats;
                    if (phase > 2) begin
                        phase = 2;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Every accepted beat is compared with the oldest
    // expected result; the receiver's stall is redrawn every cycle.
    always @(posedge i_clk) begin : watch_out
        t_sorted_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (sorted_q.size() == 0) begin
                want = '{value: '0, final_res: 1'b0, overflow: 1'b0};
                note_mismatch("result beat with nothing expected", want);
            end else begin
                want = sorted_q.pop_front();
                if (o_sorted_value !== want.value || o_final_res !== want.final_res
                        || o_overflow !== want.overflow) begin
                    note_mismatch("wrong result beat", want);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < rx_stall_pct[phase]);
    end

    initial begin
        int set_no;
        int size;

        // Directed sets. A single beat that is also last.
        queue_beat(0, 1'b1, 1'b0);
        // Both extremes, zero, minus one, and repeated values.
        queue_beat(32'sh7FFF_FFFF, 1'b0, 1'b0);
        queue_beat(32'sh8000_0000, 1'b0, 1'b0);
        queue_beat(0, 1'b0, 1'b0);
        queue_beat(-1, 1'b0, 1'b0);
        queue_beat(1, 1'b0, 1'b0);
        queue_beat(5, 1'b0, 1'b0);
        queue_beat(5, 1'b0, 1'b0);
        queue_beat(32'sh8000_0000, 1'b0, 1'b0);
        queue_beat(32'sh7FFF_FFFF, 1'b1, 1'b0);
        // Already ascending, then strictly descending.
        queue_beat(-3, 1'b0, 1'b1);
        queue_beat(-2, 1'b0, 1'b0);
        queue_beat(10, 1'b0, 1'b0);
        queue_beat(11, 1'b1, 1'b0);
        queue_beat(32'sh5555_5555, 1'b0, 1'b0);
        queue_beat(32'sh0AAA_AAAA, 1'b0, 1'b0);
        queue_beat(-32'sh0555_5555, 1'b0, 1'b0);
        queue_beat(32'shAAAA_AAAA, 1'b1, 1'b0);
        // Every value the same.
        queue_beat(-7, 1'b0, 1'b0);
        queue_beat(-7, 1'b0, 1'b0);
        queue_beat(-7, 1'b1, 1'b0);

        // Random sets, mostly small. One set fills the store exactly, and one
        // runs past it so that two beats are dropped, the last one among them.
        set_no = 0;
        while (pending_beats.size() < 350) begin
            if (set_no == 2) begin
                size = CAPACITY;
            end else if (set_no == 5) begin
                size = CAPACITY + 2;
            end else if ($urandom_range(9) == 0) begin
                size = $urandom_range(40, 17);
            end else begin
                size = $urandom_range(16, 1);
            end
            queue_random_set(size, set_no % 6 == 0);
            set_no++;
        end
        total_beats = pending_beats.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_in_valid || sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("heap_sorter: match");
        end else begin
            $display("heap_sorter: mismatch");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(LIMIT_NS);
        $display("heap_sorter: mismatch");
        $finish;
    end

endmodule
